>>> sv/yuvbgr_pkg.sv
package yuvbgr_pkg;

   // Configuration register indexes, in the order of the register map.
   typedef enum logic [3:0] {
      REG_HUE        = 4'd0,
      REG_BRIGHTNESS = 4'd1,
      REG_CONTRAST   = 4'd2,
      REG_SATURATION = 4'd3
   } reg_index_type;

   localparam int CSR_INDEX_W = 4;

   // Register stages: three for the chroma rotation, eight per pixel after that.
   localparam int NUM_STAGES  = 11;
   localparam int HUE_STAGES  = 3;
   localparam int PIX_STAGES  = NUM_STAGES - HUE_STAGES;

   // Channel slots inside a pixel.
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   // Sine and cosine for the neutral hue setting.
   localparam logic signed [15:0] Q14_ZERO = 16'sd0;
   localparam logic signed [15:0] Q14_ONE  = 16'sd16384;
   localparam logic [7:0]         NEUTRAL  = 8'd128;

   // Load strobes for the per-pixel pipeline stages.
   typedef struct packed {
      logic [PIX_STAGES-1:0] load;
   } pix_ctrl_type;

   // Picture controls that the pixel lanes read.
   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] contrast;
      logic [7:0] saturation;
   } procamp_type;

   // First quarter of a sine wave in signed Q2.14, 64 steps per quarter turn.
   localparam logic signed [15:0] QUARTER_SINE [65] = '{
      16'sd0,     16'sd402,   16'sd804,   16'sd1205,  16'sd1606,  16'sd2006,
      16'sd2404,  16'sd2801,  16'sd3196,  16'sd3590,  16'sd3981,  16'sd4370,
      16'sd4756,  16'sd5139,  16'sd5520,  16'sd5897,  16'sd6270,  16'sd6639,
      16'sd7005,  16'sd7366,  16'sd7723,  16'sd8076,  16'sd8423,  16'sd8765,
      16'sd9102,  16'sd9434,  16'sd9760,  16'sd10080, 16'sd10394, 16'sd10702,
      16'sd11003, 16'sd11297, 16'sd11585, 16'sd11866, 16'sd12140, 16'sd12406,
      16'sd12665, 16'sd12916, 16'sd13160, 16'sd13395, 16'sd13623, 16'sd13842,
      16'sd14053, 16'sd14256, 16'sd14449, 16'sd14635, 16'sd14811, 16'sd14978,
      16'sd15137, 16'sd15286, 16'sd15426, 16'sd15557, 16'sd15679, 16'sd15791,
      16'sd15893, 16'sd15986, 16'sd16069, 16'sd16143, 16'sd16207, 16'sd16261,
      16'sd16305, 16'sd16340, 16'sd16364, 16'sd16379, 16'sd16384
   };

   // Sine of k*pi/128 in Q2.14, folded out of the quarter-wave table.
   function automatic logic signed [15:0] sine_q14(input logic [7:0] k);
      logic [6:0]         phase;
      logic [6:0]         idx;
      logic signed [15:0] mag;
      begin
         phase = k[6:0];
         idx   = (phase <= 7'd64) ? phase : 7'(8'd128 - {1'b0, phase});
         mag   = QUARTER_SINE[idx];
         return k[7] ? -mag : mag;
      end
   endfunction

   function automatic logic [7:0] clamp_byte(input logic signed [21:0] x);
      begin
         if (x < 22'sd0) begin
            return 8'd0;
         end else if (x > 22'sd255) begin
            return 8'd255;
         end else begin
            return x[7:0];
         end
      end
   endfunction

   // Division by 128 that rounds toward zero.
   function automatic logic signed [21:0] div128_trunc(input logic signed [21:0] n);
      begin
         if (n < 22'sd0) begin
            return (n + 22'sd127) >>> 7;
         end else begin
            return n >>> 7;
         end
      end
   endfunction

endpackage

>>> sv/yuvbgr_req_if.sv
interface yuvbgr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_first;
   logic [7:0] luma_second;
   logic [7:0] chroma_u;
   logic [7:0] chroma_v;

   modport source (
      output valid, luma_first, luma_second, chroma_u, chroma_v,
      input  ready
   );
   modport sink (
      input  valid, luma_first, luma_second, chroma_u, chroma_v,
      output ready
   );
endinterface

>>> sv/yuvbgr_rsp_if.sv
interface yuvbgr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue_first;
   logic [7:0] green_first;
   logic [7:0] red_first;
   logic [7:0] blue_second;
   logic [7:0] green_second;
   logic [7:0] red_second;

   modport source (
      output valid, blue_first, green_first, red_first,
             blue_second, green_second, red_second,
      input  ready
   );
   modport sink (
      input  valid, blue_first, green_first, red_first,
             blue_second, green_second, red_second,
      output ready
   );
endinterface

>>> sv/yuvbgr_csr_if.sv
interface yuvbgr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [yuvbgr_pkg::CSR_INDEX_W-1:0] index;
   logic [7:0]                         data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

>>> sv/yuv422_pair_to_bgra_procamp.sv
// YUV 4:2:2 pixel pair to BGR converter with hue, brightness, contrast and
// saturation controls.
//
// The req_chan channel takes one request per pixel pair: two lumas and the
// shared U and V. The rsp_chan channel returns the blue, green and red bytes
// of both pixels; alpha is constant and is not carried. Both channels use a
// valid/ready handshake and move a request on a clock edge where both are high.
// The csr_chan channel writes the four 8-bit picture controls by index; it is
// always ready, and writes to unknown indexes are dropped. Controls should be
// changed only while no pair is in flight.
//
// The datapath is an eleven-stage pipeline, and a new pair can be accepted
// every cycle unless a stall on rsp_chan has filled the pipeline.
// Each stage holds its data only while the stage after it is full and stalled,
// so a stall on rsp_chan backs up one stage at a time and empty stages keep
// taking requests until the pipeline is full.
//
// Synchronous reset empties the pipeline and sets all four controls to the
// neutral value 128, which passes the converted colors through unchanged.
module yuv422_pair_to_bgra_procamp (
   input  logic          clock,
   input  logic          reset,
   yuvbgr_req_if.sink    req_chan,
   yuvbgr_rsp_if.source  rsp_chan,
   yuvbgr_csr_if.sink    csr_chan
);

   localparam int NS = yuvbgr_pkg::NUM_STAGES;
   localparam int HS = yuvbgr_pkg::HUE_STAGES;

   // Control registers. The hue setting is kept as its sine and cosine, which
   // are looked up when it is written.
   logic signed [15:0] sine_ff;
   logic signed [15:0] cosine_ff;
   logic [7:0]         brightness_ff;
   logic [7:0]         contrast_ff;
   logic [7:0]         saturation_ff;

   // Pipeline flow control.
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] stage_ready;
   logic [NS-1:0] stage_in_valid;
   logic [NS-1:0] load;

   // Stage 0: captured request.
   logic [7:0] luma0_s0_ff, luma1_s0_ff, u_s0_ff, v_s0_ff;

   // Stage 1: rotation products.
   logic signed [8:0]  u_c, v_c;
   logic signed [24:0] u_cos_ff, v_sin_ff, u_sin_ff, v_cos_ff;
   logic [7:0]         luma0_s1_ff, luma1_s1_ff;

   // Stage 2: rotated chroma.
   logic signed [25:0] u_sum, v_sum;
   logic [7:0]         u_rot_in, u_rot_ff, v_rot_in, v_rot_ff;
   logic [7:0]         luma0_s2_ff, luma1_s2_ff;

   yuvbgr_pkg::pix_ctrl_type pix_ctrl;
   yuvbgr_pkg::procamp_type  amp;

   // -------------------------------------------------------------------------
   // Control register writes.
   // -------------------------------------------------------------------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_ff       <= yuvbgr_pkg::Q14_ZERO;
         cosine_ff     <= yuvbgr_pkg::Q14_ONE;
         brightness_ff <= yuvbgr_pkg::NEUTRAL;
         contrast_ff   <= yuvbgr_pkg::NEUTRAL;
         saturation_ff <= yuvbgr_pkg::NEUTRAL;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            yuvbgr_pkg::REG_HUE: begin
               // Setting 128 is zero angle: sine is taken half a turn ahead,
               // cosine a further quarter turn.
               sine_ff   <= yuvbgr_pkg::sine_q14(8'(csr_chan.data + 8'd128));
               cosine_ff <= yuvbgr_pkg::sine_q14(8'(csr_chan.data + 8'd192));
            end
            yuvbgr_pkg::REG_BRIGHTNESS: begin
               brightness_ff <= csr_chan.data;
            end
            yuvbgr_pkg::REG_CONTRAST: begin
               contrast_ff <= csr_chan.data;
            end
            yuvbgr_pkg::REG_SATURATION: begin
               saturation_ff <= csr_chan.data;
            end
            default: begin
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Flow control. A stage can take new data when it is empty or when its
   // contents move on in the same cycle; the last stage is the output register.
   // -------------------------------------------------------------------------
   assign stage_ready[NS-1] = !valid_ff[NS-1] || rsp_chan.ready;

   generate
      for (genvar s = 0; s < NS - 1; s++) begin : g_ready
         assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   endgenerate

   assign stage_in_valid = {valid_ff[NS-2:0], req_chan.valid};
   assign load           = stage_ready & stage_in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= stage_in_valid[s];
            end
         end
      end
   end

   assign req_chan.ready = stage_ready[0];
   assign rsp_chan.valid = valid_ff[NS-1];

   // -------------------------------------------------------------------------
   // Hue rotation of the shared chroma, with rounding half up in Q2.14.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load[0]) begin
         luma0_s0_ff <= req_chan.luma_first;
         luma1_s0_ff <= req_chan.luma_second;
         u_s0_ff     <= req_chan.chroma_u;
         v_s0_ff     <= req_chan.chroma_v;
      end
   end

   assign u_c = $signed({1'b0, u_s0_ff}) - 9'sd128;
   assign v_c = $signed({1'b0, v_s0_ff}) - 9'sd128;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         u_cos_ff    <= 25'(u_c) * 25'(cosine_ff);
         v_sin_ff    <= 25'(v_c) * 25'(sine_ff);
         u_sin_ff    <= 25'(u_c) * 25'(sine_ff);
         v_cos_ff    <= 25'(v_c) * 25'(cosine_ff);
         luma0_s1_ff <= luma0_s0_ff;
         luma1_s1_ff <= luma1_s0_ff;
      end
   end

   // Adding half an LSB and shifting right gives the floor-based rounding.
   assign u_sum    = 26'(u_cos_ff) - 26'(v_sin_ff) + 26'sd8192;
   assign v_sum    = 26'(u_sin_ff) + 26'(v_cos_ff) + 26'sd8192;
   assign u_rot_in = yuvbgr_pkg::clamp_byte(22'(u_sum >>> 14) + 22'sd128);
   assign v_rot_in = yuvbgr_pkg::clamp_byte(22'(v_sum >>> 14) + 22'sd128);

   always_ff @(posedge clock) begin
      if (load[2]) begin
         u_rot_ff    <= u_rot_in;
         v_rot_ff    <= v_rot_in;
         luma0_s2_ff <= luma0_s1_ff;
         luma1_s2_ff <= luma1_s1_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Per-pixel conversion and picture controls, one lane for each pixel.
   // -------------------------------------------------------------------------
   assign pix_ctrl.load  = load[NS-1:HS];
   assign amp.brightness = brightness_ff;
   assign amp.contrast   = contrast_ff;
   assign amp.saturation = saturation_ff;

   yuvbgr_pixel u_pixel_first (
      .clock    (clock),
      .ctrl     (pix_ctrl),
      .amp      (amp),
      .luma     (luma0_s2_ff),
      .chroma_u (u_rot_ff),
      .chroma_v (v_rot_ff),
      .blue     (rsp_chan.blue_first),
      .green    (rsp_chan.green_first),
      .red      (rsp_chan.red_first)
   );

   yuvbgr_pixel u_pixel_second (
      .clock    (clock),
      .ctrl     (pix_ctrl),
      .amp      (amp),
      .luma     (luma1_s2_ff),
      .chroma_u (u_rot_ff),
      .chroma_v (v_rot_ff),
      .blue     (rsp_chan.blue_second),
      .green    (rsp_chan.green_second),
      .red      (rsp_chan.red_second)
   );

endmodule

>>> sv/yuvbgr_pixel.sv
module yuvbgr_pixel (
   input  logic                     clock,
   input  yuvbgr_pkg::pix_ctrl_type ctrl,
   input  yuvbgr_pkg::procamp_type  amp,
   input  logic [7:0]               luma,
   input  logic [7:0]               chroma_u,
   input  logic [7:0]               chroma_v,
   output logic [7:0]               blue,
   output logic [7:0]               green,
   output logic [7:0]               red
);

   // Stage 0: BT.601 products.
   logic signed [8:0]  luma_c;
   logic signed [8:0]  chroma_d;
   logic signed [8:0]  chroma_e;
   logic signed [19:0] luma_term_in,  luma_term_ff;
   logic signed [19:0] blue_term_in,  blue_term_ff;
   logic signed [19:0] green_term_in, green_term_ff;
   logic signed [19:0] red_term_in,   red_term_ff;

   // Stage 1: clamped RGB.
   logic [7:0] chan_in [3];
   logic [7:0] chan_ff [3];

   // Stage 2: contrast products.
   logic signed [17:0] cprod_in [3];
   logic signed [17:0] cprod_ff [3];

   // Stage 3: contrast and brightness result.
   logic signed [18:0] bright_off;
   logic signed [10:0] x1_in [3];
   logic signed [10:0] x1_ff [3];

   // Stage 4: channel sum for gray.
   logic signed [11:0] sum_in, sum_ff;
   logic signed [10:0] x1_d4_ff [3];

   // Stage 5: gray.
   logic [10:0]        sum_mag;
   logic [21:0]        third_prod;
   logic signed [10:0] gray_in, gray_ff;
   logic signed [10:0] x1_d5_ff [3];

   // Stage 6: saturation products.
   logic signed [20:0] sprod_in [3];
   logic signed [20:0] sprod_ff [3];
   logic signed [10:0] gray_d6_ff;

   // Stage 7: output.
   logic [7:0] x2_in [3];
   logic [7:0] x2_ff [3];

   assign luma_c   = $signed({1'b0, luma}) - 9'sd16;
   assign chroma_d = $signed({1'b0, chroma_u}) - 9'sd128;
   assign chroma_e = $signed({1'b0, chroma_v}) - 9'sd128;

   assign luma_term_in  = 20'(luma_c) * 20'sd298;
   assign blue_term_in  = 20'(chroma_d) * 20'sd516;
   assign green_term_in = 20'(chroma_d) * 20'sd100 + 20'(chroma_e) * 20'sd208;
   assign red_term_in   = 20'(chroma_e) * 20'sd409;

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         luma_term_ff  <= luma_term_in;
         blue_term_ff  <= blue_term_in;
         green_term_ff <= green_term_in;
         red_term_ff   <= red_term_in;
      end
   end

   // The arithmetic shift is the floor division by 256.
   always_comb begin
      chan_in[yuvbgr_pkg::CH_BLUE] = yuvbgr_pkg::clamp_byte(
         22'((luma_term_ff + blue_term_ff + 20'sd128) >>> 8));
      chan_in[yuvbgr_pkg::CH_GREEN] = yuvbgr_pkg::clamp_byte(
         22'((luma_term_ff - green_term_ff + 20'sd128) >>> 8));
      chan_in[yuvbgr_pkg::CH_RED] = yuvbgr_pkg::clamp_byte(
         22'((luma_term_ff + red_term_ff + 20'sd128) >>> 8));
   end

   assign bright_off = 19'($signed({1'b0, amp.brightness}) - 9'sd128) * 19'sd255;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cprod_in[i] = 18'($signed({1'b0, chan_ff[i]}) - 9'sd128)
                       * 18'($signed({1'b0, amp.contrast}));
         x1_in[i] = 11'(yuvbgr_pkg::div128_trunc(
                        22'(19'(cprod_ff[i]) + 19'sd16384 + bright_off)));
      end
   end

   assign sum_in = 12'(x1_ff[0]) + 12'(x1_ff[1]) + 12'(x1_ff[2]);

   // Division by three: the magnitude stays below 2048, where 683/2048 is exact
   // after truncation.
   assign sum_mag    = sum_ff[11] ? 11'(-sum_ff) : sum_ff[10:0];
   assign third_prod = 22'(sum_mag) * 22'd683;
   assign gray_in    = sum_ff[11] ? -$signed({1'b0, third_prod[20:11]})
                                  : $signed({1'b0, third_prod[20:11]});

   // A negative sum of less than one output step floors to minus one under the
   // shift where truncation would give zero; both clamp to zero, so the shift serves here.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sprod_in[i] = 21'(12'(x1_d5_ff[i]) - 12'(gray_ff))
                       * 21'($signed({1'b0, amp.saturation}));
         x2_in[i] = yuvbgr_pkg::clamp_byte(
                       ((22'(gray_d6_ff) <<< 7) + 22'(sprod_ff[i])) >>> 7);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         chan_ff <= chan_in;
      end
      if (ctrl.load[2]) begin
         cprod_ff <= cprod_in;
      end
      if (ctrl.load[3]) begin
         x1_ff <= x1_in;
      end
      if (ctrl.load[4]) begin
         sum_ff   <= sum_in;
         x1_d4_ff <= x1_ff;
      end
      if (ctrl.load[5]) begin
         gray_ff  <= gray_in;
         x1_d5_ff <= x1_d4_ff;
      end
      if (ctrl.load[6]) begin
         sprod_ff   <= sprod_in;
         gray_d6_ff <= gray_ff;
      end
      if (ctrl.load[7]) begin
         x2_ff <= x2_in;
      end
   end

   assign blue  = x2_ff[yuvbgr_pkg::CH_BLUE];
   assign green = x2_ff[yuvbgr_pkg::CH_GREEN];
   assign red   = x2_ff[yuvbgr_pkg::CH_RED];

endmodule
